// ===== rtl/orifice_pressure_equilibrium_solver_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the orifice pressure equilibrium solver unit
// Each macro expands to a labeled concurrent assertion, or to nothing.
// ---------------------------------------------------------------------------
`ifndef ORIFICE_PRESSURE_EQUILIBRIUM_SOLVER_UNIT_MACROS_SVH
`define ORIFICE_PRESSURE_EQUILIBRIUM_SOLVER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define OPES_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define OPES_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define OPES_ASSERT_IMP(label, clk, rstn, ante, cons)
`define OPES_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/opes_pkg.sv =====
// ---------------------------------------------------------------------------
// opes_pkg
// Shared types and constants for the orifice pressure solver.
// ---------------------------------------------------------------------------
`default_nettype none
package opes_pkg;
    localparam int PW  = 36;   // Q.8 pressure width
    localparam int RW  = 128;  // balance accumulator width
    localparam logic [1:0] ST_ROOT  = 2'd0;
    localparam logic [1:0] ST_FLOOR = 2'd1;
    localparam logic [1:0] ST_CEIL  = 2'd2;
    localparam logic [2:0] CFG_SUPPLY = 3'd0;
    localparam logic [2:0] CFG_TANK   = 3'd1;
    localparam logic [2:0] CFG_VAPOR  = 3'd2;
    localparam logic [2:0] CFG_GAIN   = 3'd3;
    localparam logic [2:0] CFG_LEAK   = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture item, set bounds
        logic eval_lo;  // evaluate at floor
        logic eval_hi;  // evaluate at ceiling
        logic eval_mid; // evaluate at midpoint
        logic update;   // move bound by last sign
    } opes_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic done;     // evaluation finished
        logic pos;      // Qnet > 0
        logic neg;      // Qnet < 0
    } opes_sts_t;
endpackage
`default_nettype wire

// ===== rtl/orifice_pressure_equilibrium_solver_unit.sv =====
// ---------------------------------------------------------------------------
// orifice_pressure_equilibrium_solver_unit
// Bisection search for the chamber pressure balancing orifice flows.
// ---------------------------------------------------------------------------
//  channel | ports                         | direction
//  s_      | supply_area return_area rate  | in, one word per item
//  m_      | pressure bound_status         | out, one word per item
//  cfg_    | index, data                   | in, register writes
//
//  Each balance evaluation runs two 22-step square roots on one shared
//  root unit. Synchronous active-low reset; configuration and sequencing
//  registers return to their defaults, data registers are not reset.
//  A finished word waits on m_valid; the next item is taken once it drains.
// ---------------------------------------------------------------------------
`default_nettype none
`include "orifice_pressure_equilibrium_solver_unit_macros.svh"
module orifice_pressure_equilibrium_solver_unit #(
    parameter int BISECT_STEPS = 24
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [31:0]        s_supply_area,
    input  wire logic [31:0]        s_return_area,
    input  wire logic signed [39:0] s_volume_rate,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [26:0]             m_pressure,
    output logic [1:0]              m_bound_status,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [47:0]        cfg_data
);
    logic [25:0] supply_reg, tank_reg, vapor_reg;
    logic [31:0] gain_reg;
    logic [47:0] leak_reg;
    opes_pkg::opes_cmd_t cmd;
    opes_pkg::opes_sts_t sts;
    logic [26:0] res_p, ceil_p, pres_reg;
    logic [1:0]  status;

    assign cfg_ready = 1'b1;

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            supply_reg <= 26'd20000000;
            tank_reg   <= 26'd100000;
            vapor_reg  <= 26'd2300;
            gain_reg   <= 32'd128849019;
            leak_reg   <= 48'h0001_0000_0000;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                opes_pkg::CFG_SUPPLY: supply_reg <= cfg_data[25:0];
                opes_pkg::CFG_TANK:   tank_reg   <= cfg_data[25:0];
                opes_pkg::CFG_VAPOR:  vapor_reg  <= cfg_data[25:0];
                opes_pkg::CFG_GAIN:   gain_reg   <= cfg_data[31:0];
                opes_pkg::CFG_LEAK:   leak_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    opes_ctrl #(.BISECT_STEPS(BISECT_STEPS)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .cmd(cmd), .sts(sts), .status(status)
    );

    opes_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .supply_pressure(supply_reg), .tank_pressure(tank_reg),
        .vapor_pressure(vapor_reg), .orifice_gain(gain_reg),
        .leak_conductance(leak_reg), .s_supply_area(s_supply_area),
        .s_return_area(s_return_area), .s_volume_rate(s_volume_rate),
        .res_pressure(res_p), .ceil_pressure(ceil_p)
    );

    // result word held while waiting on the sink
    always_ff @(posedge aclk) begin
        if (!m_valid) begin
            unique case (status)
                opes_pkg::ST_FLOOR: pres_reg <= {1'b0, vapor_reg};
                opes_pkg::ST_CEIL:  pres_reg <= ceil_p;
                default:            pres_reg <= res_p;
            endcase
        end
    end
    assign m_pressure     = pres_reg;
    assign m_bound_status = status;

    `OPES_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, $stable(m_pressure))
    `OPES_ASSERT_IMP(a_code, aclk, aresetn, m_valid, m_bound_status != 2'd3)
    `OPES_ASSERT_IMP(a_no_acc, aclk, aresetn, m_valid, !s_ready)
endmodule
`default_nettype wire

// ===== rtl/opes_datapath.sv =====
// ---------------------------------------------------------------------------
// opes_datapath
// Bounds, square root unit (one result bit per cycle) and balance sequence.
// ---------------------------------------------------------------------------
`default_nettype none
`include "orifice_pressure_equilibrium_solver_unit_macros.svh"
module opes_datapath (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire opes_pkg::opes_cmd_t    cmd,
    output opes_pkg::opes_sts_t         sts,
    input  wire logic [25:0]            supply_pressure,
    input  wire logic [25:0]            tank_pressure,
    input  wire logic [25:0]            vapor_pressure,
    input  wire logic [31:0]            orifice_gain,
    input  wire logic [47:0]            leak_conductance,
    input  wire logic [31:0]            s_supply_area,
    input  wire logic [31:0]            s_return_area,
    input  wire logic signed [39:0]     s_volume_rate,
    output logic [26:0]                 res_pressure,
    output logic [26:0]                 ceil_pressure
);
    localparam int PW = opes_pkg::PW;
    localparam int RW = opes_pkg::RW;

    typedef enum logic [3:0] {
        E_IDLE, E_SUPSQ, E_SUPMUL, E_SUPMUL2, E_RETSQ, E_RETMUL, E_RETMUL2,
        E_LEAK, E_CMP, E_DONE
    } eval_t;

    eval_t           es_reg, es_next;
    logic [PW-1:0]   lo_reg, hi_reg, p_reg;
    logic [31:0]     sa_reg, ra_reg;
    logic signed [39:0] vr_reg;
    logic [RW-1:0]   plus_reg, minus_reg;
    logic [RW-1:0]   rate_mag;
    logic            rate_neg;
    // square root unit: radicand up to 44 bits, root 22 bits
    logic [43:0]     rad_reg;
    logic [23:0]     rem_reg;
    logic [21:0]     root_reg;
    logic [4:0]      sq_cnt_reg;
    logic            sq_busy_reg;
    logic [63:0]     ga_reg;    // gain * area
    logic [67:0]     gp_reg;    // partial
    logic            pos_reg, neg_reg;
    logic [PW-1:0]   sup8, tnk8, ceil_q8, mid;
    logic [31:0]     ga_half;   // half of gain * area, low half first
    logic [53:0]     prod;
    logic [57:0]     div5_prod;
    logic [27:0]     s4_div5;
    logic [23:0]     trial;
    logic [43:0]     rad_start;

    assign sup8    = {2'b0, supply_pressure, 8'b0};
    assign tnk8    = {2'b0, tank_pressure, 8'b0};
    // 1.05 x supply in Q.8 = 268*s + floor(4s/5); /5 by reciprocal, exact below 2^30
    assign div5_prod = 58'({supply_pressure, 2'b00}) * 58'(30'd214748365);
    assign s4_div5   = div5_prod[57:30];
    assign ceil_q8 = PW'(supply_pressure) * 36'd268 + PW'(s4_div5);
    assign mid     = PW'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
    assign rate_neg = vr_reg[39];
    assign rate_mag = {48'b0, (rate_neg ? 40'(-vr_reg) : 40'(vr_reg)), 40'b0};
    assign trial   = {rem_reg[21:0], rad_reg[43:42]} - {root_reg, 2'b01};
    assign ga_half = (es_reg == E_SUPMUL || es_reg == E_RETMUL) ? ga_reg[31:0]
                                                                : ga_reg[63:32];
    assign prod    = 54'(ga_half) * 54'(root_reg);

    always_comb begin
        es_next = es_reg;
        unique case (es_reg)
            E_IDLE:    if (cmd.eval_lo || cmd.eval_hi || cmd.eval_mid) es_next = E_SUPSQ;
            E_SUPSQ:   if (!sq_busy_reg) es_next = E_SUPMUL;
            E_SUPMUL:  es_next = E_SUPMUL2;
            E_SUPMUL2: es_next = E_RETSQ;
            E_RETSQ:   if (!sq_busy_reg) es_next = E_RETMUL;
            E_RETMUL:  es_next = E_RETMUL2;
            E_RETMUL2: es_next = E_LEAK;
            E_LEAK:    es_next = E_CMP;
            E_CMP:     es_next = E_DONE;
            E_DONE:    es_next = E_IDLE;
            default:   es_next = E_IDLE;
        endcase
    end

    always_comb begin
        rad_start = '0;
        if (es_reg == E_IDLE || es_reg == E_SUPMUL2) begin
            if (es_reg == E_IDLE) begin
                rad_start = 44'({(sup8 > (cmd.eval_lo ? lo_reg : cmd.eval_hi ? hi_reg : mid))
                    ? sup8 - (cmd.eval_lo ? lo_reg : cmd.eval_hi ? hi_reg : mid)
                    : {PW{1'b0}}, 8'b0});
            end else begin
                rad_start = 44'({(p_reg > tnk8) ? p_reg - tnk8 : {PW{1'b0}}, 8'b0});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            es_reg      <= E_IDLE;
            sq_busy_reg <= 1'b0;
            sq_cnt_reg  <= '0;
        end else begin
            es_reg <= es_next;
            if ((es_reg == E_IDLE && es_next == E_SUPSQ) || es_reg == E_SUPMUL2) begin
                sq_busy_reg <= 1'b1;
                sq_cnt_reg  <= 5'd21;
            end else if (sq_busy_reg) begin
                if (sq_cnt_reg == 5'd0) sq_busy_reg <= 1'b0;
                sq_cnt_reg <= sq_cnt_reg - 5'd1;
            end
        end
        if (cmd.load) begin
            sa_reg <= s_supply_area;
            ra_reg <= s_return_area;
            vr_reg <= s_volume_rate;
            lo_reg <= {2'b0, vapor_pressure, 8'b0};
            hi_reg <= ceil_q8;
        end
        if (cmd.update) begin
            if (pos_reg) lo_reg <= p_reg;
            else hi_reg <= p_reg;
        end
        if (es_reg == E_IDLE && es_next == E_SUPSQ) begin
            p_reg <= cmd.eval_lo ? lo_reg : cmd.eval_hi ? hi_reg : mid;
            plus_reg  <= rate_neg ? rate_mag : '0;
            minus_reg <= rate_neg ? '0 : rate_mag;
        end
        if ((es_reg == E_IDLE && es_next == E_SUPSQ) || es_reg == E_SUPMUL2) begin
            rad_reg  <= rad_start;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (sq_busy_reg) begin
            rad_reg <= {rad_reg[41:0], 2'b00};
            if (!trial[23]) begin
                rem_reg  <= trial;
                root_reg <= {root_reg[20:0], 1'b1};
            end else begin
                rem_reg  <= {rem_reg[21:0], rad_reg[43:42]};
                root_reg <= {root_reg[20:0], 1'b0};
            end
        end
        if (es_reg == E_SUPSQ && !sq_busy_reg) ga_reg <= 64'(orifice_gain) * 64'(sa_reg);
        if (es_reg == E_RETSQ && !sq_busy_reg) ga_reg <= 64'(orifice_gain) * 64'(ra_reg);
        // orifice flow in two halves: low 32 bits of gain*area, then high 32 bits
        if (es_reg == E_SUPMUL && p_reg < sup8) plus_reg <= plus_reg + RW'(prod);
        if (es_reg == E_SUPMUL2 && p_reg < sup8) plus_reg <= plus_reg + (RW'(prod) << 32);
        if (es_reg == E_RETMUL && p_reg > tnk8) minus_reg <= minus_reg + RW'(prod);
        if (es_reg == E_RETMUL2 && p_reg > tnk8)
            minus_reg <= minus_reg + (RW'(prod) << 32);
        if (es_reg == E_RETMUL2) gp_reg <= 68'(leak_conductance[31:0]) * 68'(p_reg - tnk8);
        if (es_reg == E_LEAK && p_reg > tnk8)
            minus_reg <= minus_reg + RW'(gp_reg)
                       + (RW'(64'(leak_conductance[47:32]) * 64'(p_reg - tnk8)) << 32);
        if (es_reg == E_CMP) begin
            pos_reg <= plus_reg > minus_reg;
            neg_reg <= minus_reg > plus_reg;
        end
    end

    assign sts.done = (es_reg == E_DONE);
    assign sts.pos  = pos_reg;
    assign sts.neg  = neg_reg;
    assign res_pressure  = 27'(({1'b0, mid} + 37'd128) >> 8);
    assign ceil_pressure = 27'(({1'b0, hi_reg} + 37'd128) >> 8);

    `OPES_ASSERT_NXT(a_sq_len, aclk, aresetn, es_reg == E_SUPMUL2, sq_busy_reg)
    `OPES_ASSERT_IMP(a_sign_excl, aclk, aresetn, 1'b1, !(pos_reg && neg_reg) || !sts.done)
    `OPES_ASSERT_IMP(a_no_eval_busy, aclk, aresetn, es_reg != E_IDLE, !cmd.load)
endmodule
`default_nettype wire

// ===== rtl/opes_ctrl.sv =====
// ---------------------------------------------------------------------------
// opes_ctrl
// Sequences floor check, ceiling check and the bisection steps.
// ---------------------------------------------------------------------------
`default_nettype none
`include "orifice_pressure_equilibrium_solver_unit_macros.svh"
module opes_ctrl #(
    parameter int BISECT_STEPS = 24
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output opes_pkg::opes_cmd_t      cmd,
    input  wire opes_pkg::opes_sts_t sts,
    output logic [1:0]               status
);
    typedef enum logic [2:0] {
        S_IDLE, S_FLOOR, S_CEIL, S_MID, S_OUT
    } state_t;

    state_t                              state_reg;
    logic [$clog2(BISECT_STEPS+1)-1:0]   step_reg;
    logic                                issued_reg;
    logic                                m_valid_reg;
    logic [1:0]                          status_reg;

    assign s_ready = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;
    assign status  = status_reg;

    always_comb begin
        cmd = '0;
        cmd.load     = s_valid && s_ready;
        cmd.eval_lo  = (state_reg == S_FLOOR) && !issued_reg;
        cmd.eval_hi  = (state_reg == S_CEIL) && !issued_reg;
        cmd.eval_mid = (state_reg == S_MID) && !issued_reg;
        cmd.update   = (state_reg == S_MID) && sts.done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            issued_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            step_reg    <= '0;
            status_reg  <= opes_pkg::ST_ROOT;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (cmd.load) begin
                    state_reg  <= S_FLOOR;
                    issued_reg <= 1'b0;
                end
                S_FLOOR: begin
                    if (sts.done) begin
                        issued_reg <= 1'b0;
                        if (!sts.pos) begin
                            status_reg <= opes_pkg::ST_FLOOR;
                            state_reg  <= S_OUT;
                        end else state_reg <= S_CEIL;
                    end else issued_reg <= 1'b1;
                end
                S_CEIL: begin
                    if (sts.done) begin
                        issued_reg <= 1'b0;
                        step_reg   <= '0;
                        if (!sts.neg) begin
                            status_reg <= opes_pkg::ST_CEIL;
                            state_reg  <= S_OUT;
                        end else state_reg <= S_MID;
                    end else issued_reg <= 1'b1;
                end
                S_MID: begin
                    if (sts.done) begin
                        issued_reg <= 1'b0;
                        step_reg   <= step_reg + 1'b1;
                        if (step_reg == ($bits(step_reg))'(BISECT_STEPS - 1)) begin
                            status_reg <= opes_pkg::ST_ROOT;
                            state_reg  <= S_OUT;
                        end
                    end else issued_reg <= 1'b1;
                end
                S_OUT: begin
                    m_valid_reg <= 1'b1;
                    state_reg   <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `OPES_ASSERT_NXT(a_out_valid, aclk, aresetn, state_reg == S_OUT, m_valid_reg)
    `OPES_ASSERT_IMP(a_ready_idle, aclk, aresetn, s_ready, state_reg == S_IDLE)
    `OPES_ASSERT_IMP(a_steps, aclk, aresetn, state_reg == S_MID,
        step_reg < ($bits(step_reg))'(BISECT_STEPS))
endmodule
`default_nettype wire
